// ----- rtl/core/abs_pkg.sv -----
// shared types and codes of the admission limited burst table
package abs_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BITS    = 1'b1;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [6:0]  max_entries;
    logic [31:0] max_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] burst_bits;
    logic [47:0] send_time;
    logic [47:0] min_offset;
    logic [47:0] max_offset;
    logic [31:0] burst_id;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] assigned_id;
    logic        found;
    logic [21:0] size_bytes;
    logic [47:0] send_time;
    logic [47:0] min_offset;
    logic [47:0] max_offset;
    logic [6:0]  entry_count;
    logic [31:0] total_bits;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [23:0] bits;
    logic [47:0] send_time;
    logic [47:0] min_offset;
    logic [47:0] max_offset;
  } entry_t;

endpackage

// ----- rtl/core/admission_limited_burst_table.sv -----
// top level of the admission limited burst table with limit registers
// A request is taken when start is high and busy is low. A refused insert or an
// unused kind is answered in the cycle after the request; an insert that passes
// the limits, a remove and a query scan the single-port slot memory one slot per
// cycle, so the answer follows the read of the first matching slot, or of the
// last slot when no slot matches. A new request can be taken in the cycle that
// shows the answer. After reset a clearing pass over every slot runs with busy
// high. Each answer is shown for one cycle only, marked by out_strobe, and must
// be taken in that cycle.
module admission_limited_burst_table #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [23:0]                   in_burst_bits,
  input  logic [47:0]                   in_send_time,
  input  logic [47:0]                   in_min_offset,
  input  logic [47:0]                   in_max_offset,
  input  logic [31:0]                   in_burst_id,
  output logic                          out_strobe,
  output logic                          out_accepted,
  output logic [31:0]                   out_assigned_id,
  output logic                          out_found,
  output logic [21:0]                   out_size_bytes,
  output logic [47:0]                   out_send_time_out,
  output logic [47:0]                   out_min_offset_out,
  output logic [47:0]                   out_max_offset_out,
  output logic [6:0]                    out_entry_count,
  output logic [31:0]                   out_total_bits,
  input  logic                          cfg_we,
  input  logic [abs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  abs_pkg::cfg_t cfg_r;
  abs_pkg::req_t req;
  abs_pkg::rsp_t rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        abs_pkg::REG_MAX_ENTRIES: cfg_r.max_entries <= cfg_wdata[6:0];
        abs_pkg::REG_MAX_BITS:    cfg_r.max_bits    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign req.kind       = in_kind;
  assign req.burst_bits = in_burst_bits;
  assign req.send_time  = in_send_time;
  assign req.min_offset = in_min_offset;
  assign req.max_offset = in_max_offset;
  assign req.burst_id   = in_burst_id;

  abs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .cfg        (cfg_r),
    .rsp_strobe (out_strobe),
    .rsp        (rsp)
  );

  assign out_accepted       = rsp.accepted;
  assign out_assigned_id    = rsp.assigned_id;
  assign out_found          = rsp.found;
  assign out_size_bytes     = rsp.size_bytes;
  assign out_send_time_out  = rsp.send_time;
  assign out_min_offset_out = rsp.min_offset;
  assign out_max_offset_out = rsp.max_offset;
  assign out_entry_count    = rsp.entry_count;
  assign out_total_bits     = rsp.total_bits;

  // every request is either in work or answered in the next cycle
  a_req_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("request dropped");

  a_accept_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_accepted |-> !out_found)
    else $error("insert answer marked found");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |-> out_size_bytes == '0 && out_send_time_out == '0
      && out_min_offset_out == '0 && out_max_offset_out == '0)
    else $error("query fields set without a match");

endmodule

// ----- rtl/core/abs_mem.sv -----
// single-port slot memory with registered read data
module abs_mem #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic                       we,
  input  abs_pkg::entry_t            wdata,
  output abs_pkg::entry_t            rdata
);

  abs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/abs_ctrl.sv -----
// request sequencer: clearing pass, slot scan, admission and counters
module abs_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  abs_pkg::req_t   req,
  input  abs_pkg::cfg_t   cfg,
  output logic            rsp_strobe,
  output abs_pkg::rsp_t   rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > 7) ? CW : 7;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [AW:0]     ptr_r, ptr_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]   rd_idx_r, rd_idx_nxt;
  abs_pkg::req_t   req_r, req_nxt;
  logic [31:0]     next_id_r, next_id_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [31:0]     bits_r, bits_nxt;
  logic            strobe_r, strobe_nxt;
  abs_pkg::rsp_t   rsp_r, rsp_nxt;

  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  abs_pkg::entry_t mem_wdata;
  abs_pkg::entry_t mem_rdata;

  abs_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign rsp_strobe = strobe_r;
  assign rsp        = rsp_r;

  always_comb begin
    logic [32:0] sum;
    logic        ok;
    logic        match;
    logic        issue;
    logic [24:0] round_bits;

    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    rd_vld_nxt  = rd_vld_r;
    rd_idx_nxt  = rd_idx_r;
    req_nxt     = req_r;
    next_id_nxt = next_id_r;
    count_nxt   = count_r;
    bits_nxt    = bits_r;
    strobe_nxt  = 1'b0;
    rsp_nxt     = rsp_r;
    mem_addr    = ptr_r[AW-1:0];
    mem_we      = 1'b0;
    mem_wdata   = '0;

    sum = {1'b0, bits_r} + 33'(req.burst_bits);
    ok  = (count_r != CW'(DEPTH))
          && !(cfg.max_entries != '0 && EW'(count_r) >= EW'(cfg.max_entries))
          && !(cfg.max_bits != '0 && sum > {1'b0, cfg.max_bits})
          && !sum[32];

    issue      = (ptr_r < (AW+1)'(DEPTH));
    round_bits = 25'(mem_rdata.bits) + 25'd7;
    if (req_r.kind == abs_pkg::KIND_INSERT) begin
      match = !mem_rdata.valid;
    end else begin
      match = mem_rdata.valid && (mem_rdata.id == req_r.burst_id);
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + (AW+1)'(1);
        if (ptr_r[AW-1:0] == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_nxt    = req;
          ptr_nxt    = '0;
          rd_vld_nxt = 1'b0;
          if ((req.kind == abs_pkg::KIND_INSERT && ok)
              || req.kind == abs_pkg::KIND_REMOVE
              || req.kind == abs_pkg::KIND_QUERY) begin
            state_nxt = ST_SCAN;
          end else begin
            strobe_nxt          = 1'b1;
            rsp_nxt             = '0;
            rsp_nxt.entry_count = 7'(count_r);
            rsp_nxt.total_bits  = bits_r;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ptr_nxt = ptr_r + (AW+1)'(1);
        end
        rd_vld_nxt = issue;
        rd_idx_nxt = ptr_r[AW-1:0];
        if (rd_vld_r && (match || rd_idx_r == AW'(DEPTH - 1))) begin
          state_nxt   = ST_IDLE;
          rd_vld_nxt  = 1'b0;
          strobe_nxt  = 1'b1;
          rsp_nxt     = '0;
          count_nxt   = count_r;
          bits_nxt    = bits_r;
          if (match) begin
            mem_addr = rd_idx_r;
            case (req_r.kind)
              abs_pkg::KIND_INSERT: begin
                mem_we               = 1'b1;
                mem_wdata.valid      = 1'b1;
                mem_wdata.id         = next_id_r;
                mem_wdata.bits       = req_r.burst_bits;
                mem_wdata.send_time  = req_r.send_time;
                mem_wdata.min_offset = req_r.min_offset;
                mem_wdata.max_offset = req_r.max_offset;
                rsp_nxt.accepted     = 1'b1;
                rsp_nxt.assigned_id  = next_id_r;
                next_id_nxt          = next_id_r + 32'd1;
                count_nxt            = count_r + CW'(1);
                bits_nxt             = bits_r + 32'(req_r.burst_bits);
              end
              abs_pkg::KIND_REMOVE: begin
                mem_we        = 1'b1;
                mem_wdata     = mem_rdata;
                mem_wdata.valid = 1'b0;
                rsp_nxt.found = 1'b1;
                count_nxt     = count_r - CW'(1);
                bits_nxt      = bits_r - 32'(mem_rdata.bits);
              end
              abs_pkg::KIND_QUERY: begin
                rsp_nxt.found      = 1'b1;
                rsp_nxt.size_bytes = round_bits[24:3];
                rsp_nxt.send_time  = mem_rdata.send_time;
                rsp_nxt.min_offset = mem_rdata.min_offset;
                rsp_nxt.max_offset = mem_rdata.max_offset;
              end
              default: begin
              end
            endcase
          end
          rsp_nxt.entry_count = 7'(count_nxt);
          rsp_nxt.total_bits  = bits_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
      next_id_r <= '0;
      count_r   <= '0;
      bits_r    <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      next_id_r <= next_id_nxt;
      count_r   <= count_nxt;
      bits_r    <= bits_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    req_r    <= req_nxt;
    rsp_r    <= rsp_nxt;
  end

endmodule
